// ===== hw/rtl/tls_pkg.sv =====
// Package for the piecewise-linear trajectory sampler: constants, codes, types.
// Used by tls_core and trajectory_linear_sampler_top.
`default_nettype none
package tls_pkg;
  localparam int MAX_POINTS_DEF = 256;
  localparam int NUM_JOINTS_DEF = 6;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int POS_W = 32;
  localparam int CFG_W = 31;
  localparam logic [30:0] UNIFORM_STEP_RST = 31'd6554;
  localparam logic [30:0] MIN_SPAN_RST = 31'd66;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NEG   = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_UNIFORM_STEP = 1'b0,
    REG_MIN_SPAN     = 1'b1
  } reg_idx_t;
endpackage
`default_nettype wire

// ===== hw/rtl/trajectory_linear_sampler_top.sv =====
// Top level of the piecewise-linear trajectory sampler: stream ports, APB registers.
// Depends on tls_pkg and tls_core.
//
// Channel  Dir  Handshake                Contents
// s_axis   in   s_axis_tvalid/tready     mode, sample_time, pos_in_0..5
// m_axis   out  m_axis_tvalid/tready     pos_out_0..5, segment_end, status
// apb      in   psel/penable/pready      uniform_step (0x0), min_span (0x4)
//
// Clear acts on accept; append writes the positions one joint at a time through the
// single position-memory write port. A query walks the gaps one waypoint at a time
// (registered memory read), runs a restoring division for the blend weight, then
// blends one joint at a time; a new word is accepted only after the last one is done.
// Reset is synchronous; the stores need none.
// A pending result holds the sequencer until it moves into the output register.
`default_nettype none
module trajectory_linear_sampler_top #(
  parameter int MAX_POINTS = tls_pkg::MAX_POINTS_DEF,
  parameter int NUM_JOINTS = tls_pkg::NUM_JOINTS_DEF,
  parameter int TIME_WIDTH = tls_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // mode[1:0], sample_time[33:2], pos_in_j at 34+32j, zero pad to bytes
  input  wire logic [((34+32*NUM_JOINTS+7)/8)*8-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pos_out_j at 32j, segment_end, status, zero pad to bytes
  output logic [((10+32*NUM_JOINTS+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  localparam int OW = ((10 + 32*NUM_JOINTS + 7) / 8) * 8;
  logic [30:0] uniform_step, min_span;
  logic [NUM_JOINTS*32-1:0] out_pos;
  logic [7:0] out_seg;
  logic [1:0] out_status;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_step <= tls_pkg::UNIFORM_STEP_RST;
      min_span <= tls_pkg::MIN_SPAN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tls_pkg::REG_UNIFORM_STEP: uniform_step <= pwdata[30:0];
        tls_pkg::REG_MIN_SPAN:     min_span <= pwdata[30:0];
        default: ;
      endcase
    end
  end
  assign prdata = {1'b0, (paddr[2] == tls_pkg::REG_MIN_SPAN) ? min_span : uniform_step};

  tls_core #(.MAX_POINTS(MAX_POINTS), .NUM_JOINTS(NUM_JOINTS), .TIME_WIDTH(TIME_WIDTH)) u_core (
    .clk, .rst, .uniform_step, .min_span,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_mode(s_axis_tdata[1:0]), .in_time(s_axis_tdata[33:2]),
    .in_pos(s_axis_tdata[34 +: NUM_JOINTS*32]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_pos, .out_seg, .out_status
  );

  assign m_axis_tdata = OW'({out_status, out_seg, out_pos});
endmodule
`default_nettype wire

// ===== hw/rtl/tls_core.sv =====
// Sequencer and shared arithmetic unit of the trajectory sampler.
// Holds the gap and position memories; depends on tls_pkg.
`default_nettype none
module tls_core #(
  parameter int MAX_POINTS = tls_pkg::MAX_POINTS_DEF,
  parameter int NUM_JOINTS = tls_pkg::NUM_JOINTS_DEF,
  parameter int TIME_WIDTH = tls_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [30:0]                        uniform_step,
  input  wire logic [30:0]                        min_span,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_mode,
  input  wire logic signed [31:0]                 in_time,
  input  wire logic [NUM_JOINTS*32-1:0]           in_pos,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [NUM_JOINTS*32-1:0]                out_pos,
  output logic [7:0]                              out_seg,
  output logic [1:0]                              out_status
);
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int TW = TIME_WIDTH;
  // room for a 32-bit raw time, a 31-bit register and one carry
  localparam int XW = ((TW > 32) ? TW : 32) + 2;
  localparam int PD = MAX_POINTS * NUM_JOINTS;
  localparam int PW = $clog2(PD);
  localparam logic signed [XW-1:0] TMAX = XW'((65'sd1 <<< (TW - 1)) - 65'sd1);
  localparam logic signed [XW-1:0] TMIN = -TMAX - XW'(1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_WALK  = 10'b0000000010,
    S_WCHK  = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_RDS   = 10'b0000010000,
    S_RDE   = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_ACC   = 10'b0010000000,
    S_PICK  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic signed [TW-1:0] gap_mem [MAX_POINTS];
  logic signed [31:0]   pos_mem [PD];
  logic signed [TW-1:0] gap_rd;
  logic signed [31:0]   pos_rd;

  logic [CW-1:0]        point_count;
  logic signed [31:0]   first_raw, prev_raw;
  logic signed [31:0]   t_q;
  logic [CW-1:0]        idx;
  logic signed [XW-1:0] run, prev;
  logic                 uni;
  logic [16:0]          w;
  logic [XW:0]          rem;
  logic [4:0]           dcnt;
  logic [JW-1:0]        jn;
  logic signed [31:0]   s_val;
  logic signed [49:0]   prod;
  logic [NUM_JOINTS*32-1:0] res_pos;
  logic [7:0]           res_seg;
  logic [1:0]           res_status;
  logic [IW-1:0]        rd_idx;
  logic [PW-1:0]        pos_addr;
  logic                 ap_we;
  logic [JW-1:0]        ap_j;
  logic signed [31:0]   in_pos_q [NUM_JOINTS];
  logic [IW-1:0]        ap_slot;

  // saturating time helper
  function automatic logic signed [XW-1:0] sat(input logic signed [XW-1:0] v);
    if (v > TMAX) return TMAX;
    if (v < TMIN) return TMIN;
    return v;
  endfunction

  // append gap
  logic signed [XW-1:0] ap_last, ap_gap;
  always_comb begin
    ap_last = (point_count == '0) ? '0 : XW'(prev_raw);
    if (XW'(in_time) < ap_last) ap_last = '0;
    ap_gap = sat(XW'(in_time) - ap_last);
  end

  // gap memory
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_mode == tls_pkg::MODE_APPEND &&
        point_count < CW'(MAX_POINTS))
      gap_mem[point_count[IW-1:0]] <= ap_gap[TW-1:0];
    gap_rd <= gap_mem[rd_idx];
  end

  // position memory: append writes one joint per cycle
  always_ff @(posedge clk) begin
    if (ap_we) pos_mem[pos_addr] <= in_pos_q[ap_j];
    pos_rd <= pos_mem[pos_addr];
  end

  always_comb begin
    rd_idx = idx[IW-1:0];
    if (ap_we)
      pos_addr = PW'(ap_slot) * PW'(NUM_JOINTS) + PW'(ap_j);
    else if (state == S_RDS)
      pos_addr = PW'(idx[IW-1:0] - IW'(1)) * PW'(NUM_JOINTS) + PW'(jn);
    else
      pos_addr = PW'(idx[IW-1:0]) * PW'(NUM_JOINTS) + PW'(jn);
  end

  logic signed [XW-1:0] gap_cur, run_nx;
  always_comb begin
    if (uni) gap_cur = (idx == '0) ? '0 : XW'({1'b0, uniform_step});
    else     gap_cur = XW'(gap_rd);
    run_nx = sat(run + gap_cur);
  end

  logic [XW:0] den, num, rem2;
  always_comb begin
    den  = (XW+1)'(run - prev);
    num  = (XW+1)'(XW'(t_q) - prev);
    rem2 = {rem[XW-1:0], 1'b0};
  end

  logic signed [32:0] diff;
  logic signed [49:0] fl;
  logic signed [33:0] vsum;
  always_comb begin
    diff = 33'(pos_rd) - 33'(s_val);
    fl   = prod >>> 16;
    vsum = 34'(s_val) + 34'(fl);
  end

  logic apping;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; point_count <= '0; first_raw <= '0; prev_raw <= '0;
      out_valid <= 1'b0; ap_we <= 1'b0; apping <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (apping) begin
            if (ap_j == JW'(NUM_JOINTS - 1)) begin
              ap_we <= 1'b0; apping <= 1'b0;
            end else ap_j <= ap_j + JW'(1);
          end else if (in_valid && in_ready) begin
            t_q <= in_time;
            unique case (in_mode)
              tls_pkg::MODE_CLEAR: begin
                point_count <= '0; first_raw <= '0; prev_raw <= '0;
              end
              tls_pkg::MODE_APPEND: begin
                if (point_count < CW'(MAX_POINTS)) begin
                  for (int j = 0; j < NUM_JOINTS; j++) in_pos_q[j] <= in_pos[j*32 +: 32];
                  ap_slot <= point_count[IW-1:0];
                  ap_j <= '0; ap_we <= 1'b1; apping <= 1'b1;
                  if (point_count == '0) first_raw <= in_time;
                  prev_raw <= in_time;
                  point_count <= point_count + CW'(1);
                end
              end
              tls_pkg::MODE_QUERY: begin
                res_pos <= '0; res_seg <= '0;
                if (point_count == '0) begin
                  res_status <= tls_pkg::ST_EMPTY; state <= S_OUT;
                end else if (in_time < 0 && point_count != CW'(1)) begin
                  res_status <= tls_pkg::ST_NEG; state <= S_OUT;
                end else begin
                  res_status <= tls_pkg::ST_OK;
                  uni <= (33'(prev_raw) - 33'(first_raw)) < $signed(33'({1'b0, min_span}));
                  idx <= '0; run <= '0; prev <= '0; jn <= '0; dcnt <= '0;
                  state <= (in_time < 0) ? S_PICK : S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: state <= S_WCHK;
        S_WCHK: begin
          prev <= run; run <= run_nx;
          if (run_nx >= XW'(t_q)) begin
            if (idx == '0) state <= S_PICK;
            else begin
              rem <= '0; w <= '0; dcnt <= '0; state <= S_DIV;
            end
          end else if (idx == point_count - CW'(1)) state <= S_PICK;
          else begin idx <= idx + CW'(1); state <= S_WALK; end
        end
        S_DIV: begin
          if (dcnt == '0) begin
            if (num >= den) begin w <= 17'h10000; jn <= '0; state <= S_RDS; end
            else begin rem <= num; dcnt <= 5'd1; end
          end else begin
            if (rem2 >= den) begin rem <= rem2 - den; w <= {w[15:0], 1'b1}; end
            else begin rem <= rem2; w <= {w[15:0], 1'b0}; end
            if (dcnt == 5'd16) begin jn <= '0; state <= S_RDS; end
            dcnt <= dcnt + 5'd1;
          end
        end
        S_RDS: state <= S_RDE;
        S_RDE: begin s_val <= pos_rd; state <= S_MUL; end
        S_MUL: begin prod <= 50'(diff) * 50'($signed({1'b0, w})); state <= S_ACC; end
        S_ACC: begin
          if (vsum > 34'sd2147483647) res_pos[jn*32 +: 32] <= 32'h7FFFFFFF;
          else if (vsum < -34'sd2147483648) res_pos[jn*32 +: 32] <= 32'h80000000;
          else res_pos[jn*32 +: 32] <= vsum[31:0];
          if (jn == JW'(NUM_JOINTS - 1)) begin
            res_seg <= 8'(idx); state <= S_OUT;
          end else begin jn <= jn + JW'(1); state <= S_RDS; end
        end
        S_PICK: begin
          // copy one stored waypoint, one joint at a time
          if (dcnt == 5'd1) begin
            res_pos[jn*32 +: 32] <= pos_rd;
            if (jn == JW'(NUM_JOINTS - 1)) begin
              res_seg <= 8'(idx); state <= S_OUT; dcnt <= '0;
            end else begin jn <= jn + JW'(1); dcnt <= '0; end
          end else dcnt <= 5'd1;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_pos <= res_pos; out_seg <= res_seg; out_status <= res_status;
            out_valid <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ready only when idle and no append is still writing positions
  assign in_ready = (state == S_IDLE) && !apping;
endmodule
`default_nettype wire

// ===== tb/sv/tls_checker.sv =====
// Checker for the trajectory sampler: watches the stream and APB channels,
// predicts each query result and compares it with the output word. Depends on tls_pkg.
`timescale 1ns / 1ps
module tls_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [231:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [207:0] m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  input  wire logic         pready,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);
  localparam longint TIME_HI = 64'sd2147483647;
  localparam longint TIME_LO = -64'sd2147483648;

  typedef struct packed {
    logic [5:0][31:0] pos;
    logic [7:0]       seg;
    logic [1:0]       st;
  } sample_t;

  // Shadow copy of the waypoint store and registers
  longint              gap_mem [tls_pkg::MAX_POINTS_DEF];
  logic signed [31:0]  joint_mem [tls_pkg::MAX_POINTS_DEF][tls_pkg::NUM_JOINTS_DEF];
  int                  pt_count;
  longint              first_t, prev_t;
  logic [30:0]         step_reg, span_reg;
  sample_t             sample_q[$];

  function automatic longint clamp_time(longint v);
    if (v > TIME_HI) return TIME_HI;
    if (v < TIME_LO) return TIME_LO;
    return v;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic sample_t point_sample(int idx);
    sample_t r;
    r = '0;
    for (int j = 0; j < tls_pkg::NUM_JOINTS_DEF; j++) r.pos[j] = joint_mem[idx][j];
    r.seg = idx[7:0];
    r.st = tls_pkg::ST_OK;
    return r;
  endfunction

  // Walk the gaps and blend the two enclosing waypoints; ends and errors pick a point or a status
  function automatic sample_t sample_at(longint t);
    sample_t r;
    bit uni;
    longint run, prv, g, num, den, w, s, e, v;
    int idx;
    r = '0;
    if (pt_count == 0) begin
      r.st = tls_pkg::ST_EMPTY;
      return r;
    end
    if (t < 0) begin
      if (pt_count == 1) return point_sample(0);
      r.st = tls_pkg::ST_NEG;
      return r;
    end
    uni = (prev_t - first_t) < longint'({1'b0, span_reg});
    run = 0;
    prv = 0;
    for (idx = 0; idx < pt_count; idx++) begin
      g = uni ? ((idx == 0) ? 0 : longint'({1'b0, step_reg})) : gap_mem[idx];
      prv = run;
      run = clamp_time(run + g);
      if (run >= t) break;
    end
    if (idx == 0) return point_sample(0);
    if (idx >= pt_count) return point_sample(pt_count - 1);
    num = t - prv;
    den = run - prv;
    w = (num >= den) ? 65536 : (num <<< 16) / den;
    for (int j = 0; j < tls_pkg::NUM_JOINTS_DEF; j++) begin
      s = joint_mem[idx-1][j];
      e = joint_mem[idx][j];
      v = s + (((e - s) * w) >>> 16);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      r.pos[j] = v[31:0];
    end
    r.seg = idx[7:0];
    r.st = tls_pkg::ST_OK;
    return r;
  endfunction

  task automatic take_word(logic [231:0] d);
    tls_pkg::mode_t m;
    longint t, last;
    m = tls_pkg::mode_t'(d[1:0]);
    t = longint'($signed(d[33:2]));
    case (m)
      tls_pkg::MODE_CLEAR: begin
        pt_count = 0;
        first_t = 0;
        prev_t = 0;
      end
      tls_pkg::MODE_APPEND: begin
        if (pt_count < tls_pkg::MAX_POINTS_DEF) begin
          last = (pt_count == 0) ? 0 : prev_t;
          if (t < last) last = 0;
          gap_mem[pt_count] = clamp_time(t - last);
          for (int j = 0; j < tls_pkg::NUM_JOINTS_DEF; j++)
            joint_mem[pt_count][j] = d[34+32*j +: 32];
          if (pt_count == 0) first_t = t;
          prev_t = t;
          pt_count++;
        end
      end
      tls_pkg::MODE_QUERY: sample_q = {sample_q, sample_at(t)};
      default: ;
    endcase
  endtask

  task automatic check_word(logic [207:0] d);
    sample_t x;
    if (sample_q.size() == 0) begin
      report("output word with no result expected");
      return;
    end
    x = sample_q.pop_front();
    for (int j = 0; j < tls_pkg::NUM_JOINTS_DEF; j++)
      if (d[32*j +: 32] !== x.pos[j])
        report($sformatf("pos_out_%0d got %h want %h", j, d[32*j +: 32], x.pos[j]));
    if (d[199:192] !== x.seg)
      report($sformatf("segment_end got %0d want %0d", d[199:192], x.seg));
    if (d[201:200] !== x.st)
      report($sformatf("status got %0d want %0d", d[201:200], x.st));
  endtask

  // Sample handshakes at each edge
  always @(posedge clk) begin
    if (rst) begin
      pt_count = 0;
      first_t = 0;
      prev_t = 0;
      step_reg = tls_pkg::UNIFORM_STEP_RST;
      span_reg = tls_pkg::MIN_SPAN_RST;
      sample_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (tls_pkg::reg_idx_t'(paddr[2]) == tls_pkg::REG_UNIFORM_STEP)
          step_reg = pwdata[30:0];
        else span_reg = pwdata[30:0];
      end
      if (s_axis_tvalid && s_axis_tready) take_word(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        check_word(m_axis_tdata);
        results_seen <= results_seen + 1;
      end
    end
    pending <= sample_q.size();
  end
endmodule

// ===== tb/sv/trajectory_linear_sampler_top_tb.sv =====
// Testbench top for trajectory_linear_sampler_top: drives waypoint paths and
// queries under three pacing phases; tls_checker predicts and compares.
`timescale 1ns / 1ps
module trajectory_linear_sampler_top_tb;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * tls_pkg::MAX_POINTS_DEF + 100;
  localparam int ITEMS_PER_PHASE = 383;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [231:0] s_axis_tdata;   // mode, sample_time, pos_in_0..5, zero pad
  logic         m_axis_tvalid, m_axis_tready;
  logic [207:0] m_axis_tdata;   // pos_out_0..5, segment_end, status, zero pad
  logic         psel, penable, pwrite, pready;
  logic [2:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending, results_seen;
  int           tx_idle_pct, rx_idle_pct, words_sent, idle_cycles, phase;

  trajectory_linear_sampler_top dut (.*);

  tls_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending, .results_seen
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver stalls at random
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(tls_pkg::mode_t m, logic [31:0] t, logic [5:0][31:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, p, t, m};
    do @(posedge clk); while (!s_axis_tready);
    if (m != tls_pkg::MODE_NONE) words_sent++;
  endtask

  function automatic logic [5:0][31:0] rand_joints();
    logic [5:0][31:0] p;
    for (int j = 0; j < 6; j++) p[j] = $urandom;
    return p;
  endfunction

  task automatic reg_write(tls_pkg::reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let queued queries and trailing appends finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One path: optional clear, a run of waypoints, then queries along it
  task automatic run_path(bit force_full);
    int     n_pts, n_q, kind;
    longint cur;
    logic [31:0] dur;
    if ($urandom_range(4) != 0) send(tls_pkg::MODE_CLEAR, $urandom, rand_joints());
    n_pts = force_full ? tls_pkg::MAX_POINTS_DEF + 2
          : ($urandom_range(39) == 0) ? $urandom_range(200, 260) : $urandom_range(1, 12);
    cur = ($urandom_range(3) == 0) ? longint'($signed($urandom)) : $urandom_range(0, 32'h20000);
    for (int i = 0; i < n_pts; i++) begin
      send(tls_pkg::MODE_APPEND, cur[31:0], rand_joints());
      kind = $urandom_range(15);
      if (kind == 0) cur = cur - $urandom_range(1, 32'h40000);       // time runs backwards
      else if (kind < 3) cur = cur + $urandom_range(0, 20);          // nearly flat times
      else cur = cur + $urandom_range(1, 32'h30000);
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    end
    n_q = $urandom_range(1, 6);
    for (int i = 0; i < n_q; i++) begin
      kind = $urandom_range(15);
      if (kind == 0) dur = -$urandom_range(1, 32'h7FFFFFFF);
      else if (kind == 1) dur = $urandom;
      else if (cur > 0) dur = $urandom_range(0, 32'(cur) + 32'h10000);
      else dur = $urandom_range(0, 32'h40000);
      send(tls_pkg::MODE_QUERY, dur, rand_joints());
      if ($urandom_range(9) == 0) send(tls_pkg::MODE_NONE, $urandom, rand_joints());
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    words_sent = 0;
    tx_idle_pct = 34;
    rx_idle_pct = 87;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, negative durations, extremes, backwards time
    send(tls_pkg::MODE_QUERY, 32'h0, '0);
    send(tls_pkg::MODE_QUERY, 32'h8000_0000, '0);
    send(tls_pkg::MODE_APPEND, 32'h8000_0000, {6{32'h8000_0000}});
    send(tls_pkg::MODE_QUERY, 32'hFFFF_FFFF, '0);
    send(tls_pkg::MODE_QUERY, 32'h0, '0);
    send(tls_pkg::MODE_APPEND, 32'h7FFF_FFFF, {6{32'h7FFF_FFFF}});
    send(tls_pkg::MODE_QUERY, 32'h0000_1000, '0);
    send(tls_pkg::MODE_QUERY, 32'h7FFF_FFFF, '0);
    send(tls_pkg::MODE_QUERY, 32'hFFFF_FFFF, '0);
    send(tls_pkg::MODE_NONE, 32'hFFFF_FFFF, {6{32'hFFFF_FFFF}});
    send(tls_pkg::MODE_CLEAR, 32'h0, '0);
    send(tls_pkg::MODE_QUERY, 32'h0001_0000, '0);
    send(tls_pkg::MODE_APPEND, 32'h0, rand_joints());
    send(tls_pkg::MODE_APPEND, 32'h0001_0000, rand_joints());
    send(tls_pkg::MODE_APPEND, 32'h0000_8000, rand_joints());
    send(tls_pkg::MODE_QUERY, 32'h0001_8000, '0);
    send(tls_pkg::MODE_QUERY, 32'h0000_5000, '0);
    send(tls_pkg::MODE_QUERY, 32'h0004_0000, '0);
    send(tls_pkg::MODE_CLEAR, 32'h0, '0);
    send(tls_pkg::MODE_APPEND, 32'h0000_0010, rand_joints());
    send(tls_pkg::MODE_APPEND, 32'h0000_0011, rand_joints());
    send(tls_pkg::MODE_APPEND, 32'h0000_0012, rand_joints());
    send(tls_pkg::MODE_QUERY, 32'h0000_2000, '0);
    send(tls_pkg::MODE_QUERY, 32'h0000_0000, '0);

    // Random paths, one register setting and pacing per phase
    for (phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          reg_write(tls_pkg::REG_UNIFORM_STEP, 32'h0001_0000);
          reg_write(tls_pkg::REG_MIN_SPAN, 32'd66);
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 34;
          reg_write(tls_pkg::REG_UNIFORM_STEP, 32'h7FFF_FFFF);
          reg_write(tls_pkg::REG_MIN_SPAN, 32'h7FFF_FFFF);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          reg_write(tls_pkg::REG_UNIFORM_STEP, 32'h0);
          reg_write(tls_pkg::REG_MIN_SPAN, 32'h0);
        end
      endcase
      run_path(phase == 2);
      while (words_sent < ITEMS_PER_PHASE * (phase + 1) + 24) run_path(1'b0);
    end
    drain();

    $display("run covered %0d input words and %0d checked results", words_sent, results_seen);
    $display("three register settings, paced sender/receiver stalls and a full store");
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== trajectory_linear_sampler_top.f =====
hw/rtl/tls_pkg.sv
hw/rtl/tls_core.sv
hw/rtl/trajectory_linear_sampler_top.sv
tb/sv/tls_checker.sv
tb/sv/trajectory_linear_sampler_top_tb.sv
